>>> rtl/sfe_pkg.sv
// Package with the types, constants and helpers of the step command queue.
`timescale 1ns / 1ps

package sfe_pkg;

  localparam int unsigned QUEUE_DEPTH = 4096;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned POS_W       = 32;

  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  // One stored step command, step bit of X in bit 0.
  typedef struct packed {
    logic dir_z;
    logic step_z;
    logic dir_y;
    logic step_y;
    logic dir_x;
    logic step_x;
  } step_cmd_t;

  typedef struct packed {
    logic func;
    logic step_x;
    logic dir_x;
    logic step_y;
    logic dir_y;
    logic step_z;
    logic dir_z;
    logic estop_in;
    logic alarm_in;
    logic endstop_in;
  } cmd_item_t;

  typedef struct packed {
    logic push_accepted;
    logic pulse_x;
    logic pulse_y;
    logic pulse_z;
    logic dir_x_pin;
    logic dir_y_pin;
    logic dir_z_pin;
    logic motor_disable;
    pos_t pos_x;
    pos_t pos_y;
    pos_t pos_z;
    logic queue_empty;
  } res_item_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic pos_t axis_move(input pos_t pos, input logic pulse, input logic dir);
    pos_t r;
    if (!pulse) begin
      r = pos;
    end else if (dir) begin
      r = pos + pos_t'(1);
    end else begin
      r = pos - pos_t'(1);
    end
    return r;
  endfunction

endpackage

>>> rtl/sfe_if.sv
// Valid and ready channel interfaces for the command and result transfers.
`timescale 1ns / 1ps

interface sfe_cmd_if import sfe_pkg::*; ();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfe_res_if import sfe_pkg::*; ();
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/step_command_fifo_executor_top.sv
// Top level of the three-axis step command queue and step executor.
`timescale 1ns / 1ps

// One command or tick transfer is taken every clock cycle, and its result is presented on the
// result channel from the result register: taking it updates the queue pointers and reads
// the command memory through its single registered read port, and the registered command is
// then applied to the direction and position registers and loaded into the result register. When the
// result is not taken, the whole pipeline holds and the command side stops accepting. The
// 4096-entry command memory needs no clearing after reset.
module step_command_fifo_executor_top import sfe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfe_cmd_if.sink          cmd_i,
  sfe_res_if.source        res_o
);

  step_cmd_t mem [QUEUE_DEPTH];

  ptr_t      wr_q, wr_d;
  ptr_t      rd_q, rd_d;
  logic      advance, accept, is_tick, fault, empty, full;
  logic      push_ok, pop, flush;
  step_cmd_t cmd_word;

  logic      s1_valid_q;
  logic      s1_push_acc_q;
  logic      s1_pop_q;
  logic      s1_disable_q;
  logic      s1_empty_q;
  step_cmd_t rd_data_q;

  logic [2:0] dir_q, dir_d;
  pos_t       pos_x_q, pos_x_d;
  pos_t       pos_y_q, pos_y_d;
  pos_t       pos_z_q, pos_z_d;
  logic       pulse_x, pulse_y, pulse_z;

  logic       out_valid_q;
  res_item_t  out_data_q;
  res_item_t  out_data_d;

  assign advance = !out_valid_q || res_o.ready;
  assign accept  = cmd_i.valid && advance;
  assign cmd_i.ready = advance;

  assign is_tick = (cmd_i.data.func == FUNC_TICK);
  assign fault   = cmd_i.data.estop_in || cmd_i.data.alarm_in || cmd_i.data.endstop_in;
  assign empty   = (rd_q == wr_q);
  assign full    = (ring_next(wr_q) == rd_q);
  assign push_ok = accept && !is_tick && !full;
  assign pop     = accept && is_tick && !fault && !empty;
  assign flush   = accept && is_tick && fault;

  assign cmd_word = '{dir_z: cmd_i.data.dir_z, step_z: cmd_i.data.step_z,
                      dir_y: cmd_i.data.dir_y, step_y: cmd_i.data.step_y,
                      dir_x: cmd_i.data.dir_x, step_x: cmd_i.data.step_x};

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_ok) begin
      wr_d = ring_next(wr_q);
    end
    if (pop) begin
      rd_d = ring_next(rd_q);
    end else if (flush) begin
      rd_d = wr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_q] <= cmd_word;
    end
    if (pop) begin
      rd_data_q <= mem[rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q          <= '0;
      rd_q          <= '0;
      s1_valid_q    <= 1'b0;
      s1_push_acc_q <= 1'b0;
      s1_pop_q      <= 1'b0;
      s1_disable_q  <= 1'b0;
      s1_empty_q    <= 1'b1;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      if (accept) begin
        s1_valid_q    <= 1'b1;
        s1_push_acc_q <= push_ok;
        s1_pop_q      <= pop;
        s1_disable_q  <= flush;
        s1_empty_q    <= (rd_d == wr_d);
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Second stage: apply the dequeued command to the held pins and counters.
  always_comb begin
    pulse_x = s1_pop_q && rd_data_q.step_x;
    pulse_y = s1_pop_q && rd_data_q.step_y;
    pulse_z = s1_pop_q && rd_data_q.step_z;
    dir_d   = dir_q;
    if (pulse_x) begin
      dir_d[0] = rd_data_q.dir_x;
    end
    if (pulse_y) begin
      dir_d[1] = rd_data_q.dir_y;
    end
    if (pulse_z) begin
      dir_d[2] = rd_data_q.dir_z;
    end
    pos_x_d = axis_move(pos_x_q, pulse_x, rd_data_q.dir_x);
    pos_y_d = axis_move(pos_y_q, pulse_y, rd_data_q.dir_y);
    pos_z_d = axis_move(pos_z_q, pulse_z, rd_data_q.dir_z);

    out_data_d.push_accepted = s1_push_acc_q;
    out_data_d.pulse_x       = pulse_x;
    out_data_d.pulse_y       = pulse_y;
    out_data_d.pulse_z       = pulse_z;
    out_data_d.dir_x_pin     = dir_d[0];
    out_data_d.dir_y_pin     = dir_d[1];
    out_data_d.dir_z_pin     = dir_d[2];
    out_data_d.motor_disable = s1_disable_q;
    out_data_d.pos_x         = pos_x_d;
    out_data_d.pos_y         = pos_y_d;
    out_data_d.pos_z         = pos_z_d;
    out_data_d.queue_empty   = s1_empty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_z_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        dir_q   <= dir_d;
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        pos_z_q <= pos_z_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_fault_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.motor_disable |->
      !(out_data_q.pulse_x || out_data_q.pulse_y || out_data_q.pulse_z))
    else $error("Pulse issued on a tick that saw a fault.");

  a_push_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.push_accepted |->
      !(out_data_q.pulse_x || out_data_q.pulse_y || out_data_q.motor_disable))
    else $error("Push transfer produced tick outputs.");

  a_flush_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |=> s1_empty_q && (rd_q == wr_q))
    else $error("Queue not empty after a fault flush.");

  a_pos_x_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && s1_valid_q && pulse_x) |=> $stable(pos_x_q))
    else $error("X position changed without a step pulse.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !push_ok && (rd_q != wr_q))
    else $error("Dequeue from an empty queue.");
`endif

endmodule

>>> verif/step_command_fifo_executor_top_tb.sv
// Self-checking testbench for the step command queue: directed and random traffic.
`timescale 1ns / 1ps

module step_command_fifo_executor_top_tb;
  import sfe_pkg::*;

  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned RANDOM_ITEMS  = 1125;
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CALM_FROM     = 700;
  localparam int unsigned CALM_TO       = 1700;
  localparam int unsigned DRAIN_CYCLES  = 10;

  logic clk_i;
  logic rst_ni;

  sfe_cmd_if cmd_if ();
  sfe_res_if res_if ();

  step_command_fifo_executor_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  cmd_item_t   cmd_backlog[$];
  res_item_t   expected_results[$];
  step_cmd_t   queued_cmds[$];
  pos_t        axis_pos[3];
  logic [2:0]  dir_levels;
  logic        cmd_taken;
  logic        long_hold_done;
  int unsigned hold_left;
  int unsigned cmds_taken;
  int unsigned results_seen;
  int unsigned error_count;

  function automatic res_item_t predict_result(input cmd_item_t it);
    res_item_t r;
    step_cmd_t c;
    r = '0;
    if (func_e'(it.func) == FUNC_PUSH) begin
      if (queued_cmds.size() < QUEUE_DEPTH - 1) begin
        c = {it.dir_z, it.step_z, it.dir_y, it.step_y, it.dir_x, it.step_x};
        queued_cmds.push_back(c);
        r.push_accepted = 1'b1;
      end
    end else if (it.estop_in || it.alarm_in || it.endstop_in) begin
      r.motor_disable = 1'b1;
      queued_cmds.delete();
    end else if (queued_cmds.size() != 0) begin
      c = queued_cmds.pop_front();
      for (int a = 0; a < 3; a++) begin
        if (c[2*a]) begin
          dir_levels[a] = c[2*a+1];
          axis_pos[a] = c[2*a+1] ? axis_pos[a] + pos_t'(1) : axis_pos[a] - pos_t'(1);
        end
      end
      r.pulse_x = c.step_x;
      r.pulse_y = c.step_y;
      r.pulse_z = c.step_z;
    end
    r.dir_x_pin   = dir_levels[0];
    r.dir_y_pin   = dir_levels[1];
    r.dir_z_pin   = dir_levels[2];
    r.pos_x       = axis_pos[0];
    r.pos_y       = axis_pos[1];
    r.pos_z       = axis_pos[2];
    r.queue_empty = (queued_cmds.size() == 0);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  function automatic void compare_result(input res_item_t exp_r, input res_item_t act_r);
    check_field("push_accepted", 32'(exp_r.push_accepted), 32'(act_r.push_accepted));
    check_field("pulse_x", 32'(exp_r.pulse_x), 32'(act_r.pulse_x));
    check_field("pulse_y", 32'(exp_r.pulse_y), 32'(act_r.pulse_y));
    check_field("pulse_z", 32'(exp_r.pulse_z), 32'(act_r.pulse_z));
    check_field("dir_x_pin", 32'(exp_r.dir_x_pin), 32'(act_r.dir_x_pin));
    check_field("dir_y_pin", 32'(exp_r.dir_y_pin), 32'(act_r.dir_y_pin));
    check_field("dir_z_pin", 32'(exp_r.dir_z_pin), 32'(act_r.dir_z_pin));
    check_field("motor_disable", 32'(exp_r.motor_disable), 32'(act_r.motor_disable));
    check_field("pos_x", exp_r.pos_x, act_r.pos_x);
    check_field("pos_y", exp_r.pos_y, act_r.pos_y);
    check_field("pos_z", exp_r.pos_z, act_r.pos_z);
    check_field("queue_empty", 32'(exp_r.queue_empty), 32'(act_r.queue_empty));
  endfunction

  // Fields that the operation does not use are filled with noise.
  function automatic void add_push(input step_cmd_t c);
    cmd_item_t it;
    it        = cmd_item_t'(10'($urandom_range(1023)));
    it.func   = FUNC_PUSH;
    it.step_x = c.step_x;
    it.dir_x  = c.dir_x;
    it.step_y = c.step_y;
    it.dir_y  = c.dir_y;
    it.step_z = c.step_z;
    it.dir_z  = c.dir_z;
    cmd_backlog.push_back(it);
  endfunction

  function automatic void add_tick(input logic [2:0] faults);
    cmd_item_t it;
    it            = cmd_item_t'(10'($urandom_range(1023)));
    it.func       = FUNC_TICK;
    it.estop_in   = faults[2];
    it.alarm_in   = faults[1];
    it.endstop_in = faults[0];
    cmd_backlog.push_back(it);
  endfunction

  function automatic logic calm_stretch();
    return (cmds_taken >= CALM_FROM) && (cmds_taken < CALM_TO);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    cmd_taken <= rst_ni && cmd_if.valid && cmd_if.ready;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      expected_results.push_back(predict_result(cmd_if.data));
      cmds_taken++;
    end
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result transfer arrived with no expectation pending");
        error_count++;
      end else begin
        compare_result(expected_results.pop_front(), res_if.data);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (!cmd_if.valid || cmd_taken) begin
      if (cmd_backlog.size() != 0 && (calm_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= cmd_backlog.pop_front();
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // The long hold lets the command side keep offering until the block stalls its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= HOLD_AT) begin
      res_if.ready   <= 1'b0;
      hold_left      <= HOLD_CYCLES;
      long_hold_done <= 1'b1;
    end else if (calm_stretch()) begin
      res_if.ready <= 1'b1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    int unsigned push_pct;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.data      = '0;
    res_if.ready     = 1'b0;
    cmd_taken        = 1'b0;
    long_hold_done   = 1'b0;
    hold_left        = 0;
    cmds_taken       = 0;
    results_seen     = 0;
    error_count      = 0;
    dir_levels       = '0;
    axis_pos[0]      = '0;
    axis_pos[1]      = '0;
    axis_pos[2]      = '0;

    add_tick(3'b000);
    add_tick(3'b100);
    add_tick(3'b010);
    add_tick(3'b001);
    add_tick(3'b111);
    add_push(step_cmd_t'(6'b000000));
    add_tick(3'b000);
    add_push(step_cmd_t'(6'b111111));
    add_push(step_cmd_t'(6'b010101));
    add_push(step_cmd_t'(6'b000011));
    add_push(step_cmd_t'(6'b000100));
    add_push(step_cmd_t'(6'b110000));
    repeat (5) add_tick(3'b000);
    add_push(step_cmd_t'(6'($urandom_range(63))));
    add_push(step_cmd_t'(6'($urandom_range(63))));
    add_tick(3'b101);
    add_tick(3'b000);

    push_pct = 50;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        push_pct = $urandom_range(30, 70);
      end
      if ($urandom_range(99) < push_pct) begin
        add_push(step_cmd_t'(6'($urandom_range(63))));
      end else if ($urandom_range(19) == 0) begin
        add_tick(3'($urandom_range(1, 7)));
      end else begin
        add_tick(3'b000);
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (cmd_backlog.size() == 0 && !cmd_if.valid);
    wait (expected_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
